FILE: rtl/core/pta_pkg.sv
// ----------------------------------------------------------------------------
// pta_pkg
// Shared types and constants for the peer table with aging.
// ----------------------------------------------------------------------------
`default_nettype none

package pta_pkg;

  localparam int PEER_SLOTS = 16;
  localparam int IDX_W      = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CNT_W      = $clog2(PEER_SLOTS + 1);
  localparam int KEY_W      = 48;
  localparam int TIME_W     = 32;
  localparam int TMO_W      = 16;
  localparam int ACT_W      = 2;
  localparam int SLOT_W     = 4;
  localparam int STAT_W     = 3;
  localparam int PCNT_W     = 5;

  localparam logic [TMO_W-1:0] TIMEOUT_RST = TMO_W'(1000);

  // actions
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SWEEP  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;

  // result status
  localparam logic [STAT_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_SWEPT    = 3'd5;
  localparam logic [STAT_W-1:0] ST_SKIPPED  = 3'd6;

  typedef logic [IDX_W-1:0] idx_t;

  // sequencer -> slot store
  typedef struct packed {
    logic rd_en;
    idx_t rd_idx;
    logic wr_en;   // write key/stamp and mark slot used
    idx_t wr_idx;
    logic clr_en;  // mark slot free
    idx_t clr_idx;
  } store_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/peer_table_with_aging_unit.sv
// ----------------------------------------------------------------------------
// peer_table_with_aging_unit
// Peer address table with add, remove and timed aging sweep.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  request   | start / busy         | in_action, in_mac_address, in_now_time
//  result    | out_valid (strobe)   | out_slot, out_status, out_peer_count,
//            |                      | out_removed_count
//  config    | cfg_we               | cfg_wdata (timeout_ms)
//
//  A request walks every slot through the single key/stamp memory read port,
//  then passes the drain step and the result step; a sweep first passes the
//  period check. A sweep that the period check skips goes straight to the
//  result step, and so does a no-op.
//  The result strobe comes in the cycle after the last step; busy drops at the
//  same time, so the next request can start while the result is on the ports.
//  Synchronous active-low reset empties the table, timeout_ms returns to 1000.
//  The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_table_with_aging_unit import pta_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [ACT_W-1:0]     in_action,
  input  wire logic [KEY_W-1:0]     in_mac_address,
  input  wire logic [TIME_W-1:0]    in_now_time,
  input  wire logic                 cfg_we,
  input  wire logic [TMO_W-1:0]     cfg_wdata,
  output logic                      out_valid,
  output logic [SLOT_W-1:0]         out_slot,
  output logic [STAT_W-1:0]         out_status,
  output logic [PCNT_W-1:0]         out_peer_count,
  output logic [PCNT_W-1:0]         out_removed_count
);

  store_ctl_t            st_ctl;
  logic [KEY_W-1:0]      wr_key;
  logic [TIME_W-1:0]     wr_stamp;
  logic [KEY_W-1:0]      rd_key;
  logic [TIME_W-1:0]     rd_stamp;
  logic [PEER_SLOTS-1:0] used;

  pta_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (st_ctl),
    .wr_key   (wr_key),
    .wr_stamp (wr_stamp),
    .rd_key   (rd_key),
    .rd_stamp (rd_stamp),
    .used     (used)
  );

  pta_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_action         (in_action),
    .in_mac_address    (in_mac_address),
    .in_now_time       (in_now_time),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .busy              (busy),
    .st_ctl            (st_ctl),
    .wr_key            (wr_key),
    .wr_stamp          (wr_stamp),
    .rd_key            (rd_key),
    .rd_stamp          (rd_stamp),
    .used              (used),
    .out_valid         (out_valid),
    .out_slot          (out_slot),
    .out_status        (out_status),
    .out_peer_count    (out_peer_count),
    .out_removed_count (out_removed_count)
  );

endmodule

`default_nettype wire

FILE: rtl/core/pta_cmp.sv
// ----------------------------------------------------------------------------
// pta_cmp
// Shared compare unit: key equality and wrapped time age against timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module pta_cmp import pta_pkg::*; (
  input  wire logic [KEY_W-1:0]  key_a,
  input  wire logic [KEY_W-1:0]  key_b,
  input  wire logic [TIME_W-1:0] time_a,
  input  wire logic [TIME_W-1:0] time_b,
  input  wire logic [TMO_W-1:0]  limit,
  output logic                   key_match,
  output logic                   aged
);

  logic [TIME_W-1:0] diff;

  // modulo 2^32 difference
  assign diff      = time_a - time_b;
  assign aged      = (diff >= TIME_W'(limit));
  assign key_match = (key_a == key_b);

endmodule

`default_nettype wire

FILE: rtl/core/pta_store.sv
// ----------------------------------------------------------------------------
// pta_store
// Slot store: key and stamp memories with registered read, used bits in flops.
// ----------------------------------------------------------------------------
`default_nettype none

module pta_store import pta_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire store_ctl_t            ctl,
  input  wire logic [KEY_W-1:0]      wr_key,
  input  wire logic [TIME_W-1:0]     wr_stamp,
  output logic [KEY_W-1:0]           rd_key,
  output logic [TIME_W-1:0]          rd_stamp,
  output logic [PEER_SLOTS-1:0]      used
);

  logic [KEY_W-1:0]      key_mem   [PEER_SLOTS];
  logic [TIME_W-1:0]     stamp_mem [PEER_SLOTS];
  logic [KEY_W-1:0]      rd_key_r;
  logic [TIME_W-1:0]     rd_stamp_r;
  logic [PEER_SLOTS-1:0] used_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      key_mem[ctl.wr_idx]   <= wr_key;
      stamp_mem[ctl.wr_idx] <= wr_stamp;
    end
    if (ctl.rd_en) begin
      rd_key_r   <= key_mem[ctl.rd_idx];
      rd_stamp_r <= stamp_mem[ctl.rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      if (ctl.wr_en)
        used_r[ctl.wr_idx] <= 1'b1;
      if (ctl.clr_en)
        used_r[ctl.clr_idx] <= 1'b0;
    end
  end

  assign rd_key   = rd_key_r;
  assign rd_stamp = rd_stamp_r;
  assign used     = used_r;

endmodule

`default_nettype wire

FILE: rtl/core/pta_ctrl.sv
// ----------------------------------------------------------------------------
// pta_ctrl
// Sequencer: walks the slots once per add, remove or due sweep through the shared compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pta_ctrl import pta_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [ACT_W-1:0]      in_action,
  input  wire logic [KEY_W-1:0]      in_mac_address,
  input  wire logic [TIME_W-1:0]     in_now_time,
  input  wire logic                  cfg_we,
  input  wire logic [TMO_W-1:0]      cfg_wdata,
  output logic                       busy,
  output store_ctl_t                 st_ctl,
  output logic [KEY_W-1:0]           wr_key,
  output logic [TIME_W-1:0]          wr_stamp,
  input  wire logic [KEY_W-1:0]      rd_key,
  input  wire logic [TIME_W-1:0]     rd_stamp,
  input  wire logic [PEER_SLOTS-1:0] used,
  output logic                       out_valid,
  output logic [SLOT_W-1:0]          out_slot,
  output logic [STAT_W-1:0]          out_status,
  output logic [PCNT_W-1:0]          out_peer_count,
  output logic [PCNT_W-1:0]          out_removed_count
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GATE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam idx_t LAST_IDX = IDX_W'(PEER_SLOTS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [ACT_W-1:0]  act_r;
  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] now_r;
  logic [TMO_W-1:0]  timeout_r;
  logic [TIME_W-1:0] last_sweep_r;
  idx_t              cnt_r;
  logic              pv_r;
  idx_t              pidx_r;
  logic              found_r;
  idx_t              fidx_r;
  logic              free_r;
  idx_t              freeidx_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  live_r;
  logic              skip_r;

  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [STAT_W-1:0] out_status_r;
  logic [PCNT_W-1:0] out_pcnt_r;
  logic [PCNT_W-1:0] out_rem_r;
  logic [SLOT_W-1:0] out_slot_nxt;
  logic [STAT_W-1:0] out_status_nxt;
  logic [PCNT_W-1:0] out_pcnt_nxt;
  logic [PCNT_W-1:0] out_rem_nxt;

  logic [TIME_W-1:0] cmp_time_b;
  logic              key_match;
  logic              aged;
  logic              cur_used;
  logic              sweep_hit;
  logic              accept;

  assign accept     = start && (state_r == S_IDLE);
  assign cmp_time_b = (state_r == S_GATE) ? last_sweep_r : rd_stamp;
  assign cur_used   = used[pidx_r];
  assign sweep_hit  = pv_r && (act_r == ACT_SWEEP) && cur_used && aged;

  pta_cmp u_cmp (
    .key_a     (key_r),
    .key_b     (rd_key),
    .time_a    (now_r),
    .time_b    (cmp_time_b),
    .limit     (timeout_r),
    .key_match (key_match),
    .aged      (aged)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_action == ACT_SWEEP)
            state_nxt = S_GATE;
          else if (in_action == ACT_NOP)
            state_nxt = S_FIN;
          else
            state_nxt = S_SCAN;
        end
      end
      S_GATE:  state_nxt = aged ? S_SCAN : S_FIN;
      S_SCAN:  state_nxt = (cnt_r == LAST_IDX) ? S_DRAIN : S_SCAN;
      S_DRAIN: state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // store control
  always_comb begin
    st_ctl        = '0;
    st_ctl.rd_en  = (state_r == S_SCAN);
    st_ctl.rd_idx = cnt_r;
    st_ctl.wr_idx = freeidx_r;
    if (sweep_hit) begin
      st_ctl.clr_en  = 1'b1;
      st_ctl.clr_idx = pidx_r;
    end
    if (state_r == S_FIN) begin
      if (act_r == ACT_ADD && !found_r && free_r)
        st_ctl.wr_en = 1'b1;
      if (act_r == ACT_REMOVE && found_r) begin
        st_ctl.clr_en  = 1'b1;
        st_ctl.clr_idx = fidx_r;
      end
    end
  end

  assign wr_key   = key_r;
  assign wr_stamp = now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      timeout_r    <= TIMEOUT_RST;
      last_sweep_r <= '0;
      live_r       <= '0;
      pv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= (state_r == S_SCAN);
      out_valid_r <= (state_r == S_FIN);
      if (cfg_we)
        timeout_r <= cfg_wdata;
      if (state_r == S_GATE && aged)
        last_sweep_r <= now_r;
      if (sweep_hit)
        live_r <= live_r - CNT_W'(1);
      if (state_r == S_FIN) begin
        if (act_r == ACT_ADD && !found_r && free_r)
          live_r <= live_r + CNT_W'(1);
        if (act_r == ACT_REMOVE && found_r)
          live_r <= live_r - CNT_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= in_action;
      key_r     <= in_mac_address;
      now_r     <= in_now_time;
      cnt_r     <= '0;
      found_r   <= 1'b0;
      free_r    <= 1'b0;
      fidx_r    <= '0;
      freeidx_r <= '0;
      rem_r     <= '0;
      skip_r    <= 1'b0;
    end
    if (state_r == S_GATE)
      skip_r <= !aged;
    if (state_r == S_SCAN)
      cnt_r <= cnt_r + IDX_W'(1);
    pidx_r <= cnt_r;
    if (pv_r && act_r != ACT_SWEEP) begin
      if (cur_used && key_match && !found_r) begin
        found_r <= 1'b1;
        fidx_r  <= pidx_r;
      end
      if (!cur_used && !free_r) begin
        free_r    <= 1'b1;
        freeidx_r <= pidx_r;
      end
    end
    if (sweep_hit)
      rem_r <= rem_r + CNT_W'(1);
  end

  // result fields, taken in the final step
  always_comb begin
    out_slot_nxt   = '0;
    out_rem_nxt    = '0;
    out_pcnt_nxt   = PCNT_W'(live_r);
    out_status_nxt = ST_SKIPPED;
    case (act_r)
      ACT_ADD: begin
        if (found_r) begin
          out_slot_nxt   = SLOT_W'(fidx_r);
          out_status_nxt = ST_PRESENT;
        end else if (free_r) begin
          out_slot_nxt   = SLOT_W'(freeidx_r);
          out_status_nxt = ST_ADDED;
          out_pcnt_nxt   = PCNT_W'(live_r + CNT_W'(1));
        end else begin
          out_status_nxt = ST_FULL;
        end
      end
      ACT_REMOVE: begin
        if (found_r) begin
          out_slot_nxt   = SLOT_W'(fidx_r);
          out_status_nxt = ST_REMOVED;
          out_pcnt_nxt   = PCNT_W'(live_r - CNT_W'(1));
        end else begin
          out_status_nxt = ST_NOTFOUND;
        end
      end
      ACT_SWEEP: begin
        if (!skip_r) begin
          out_status_nxt = ST_SWEPT;
          out_rem_nxt    = PCNT_W'(rem_r);
        end
      end
      default: out_status_nxt = ST_SKIPPED;
    endcase
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (state_r == S_FIN) begin
      out_slot_r   <= out_slot_nxt;
      out_rem_r    <= out_rem_nxt;
      out_pcnt_r   <= out_pcnt_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_slot          = out_slot_r;
  assign out_status        = out_status_r;
  assign out_peer_count    = out_pcnt_r;
  assign out_removed_count = out_rem_r;

endmodule

`default_nettype wire

FILE: rtl/core/pta_chk.sv
// ----------------------------------------------------------------------------
// pta_chk
// Port-level checks on the peer table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pta_chk import pta_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [SLOT_W-1:0] out_slot,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic [PCNT_W-1:0] out_peer_count,
  input wire logic [PCNT_W-1:0] out_removed_count
);

  // an accepted request always holds the unit busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but unit not busy");

  // a result strobe is never back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_NOTFOUND ||
                   out_status == ST_SWEPT || out_status == ST_SKIPPED))
    |-> (out_slot == '0))
    else $error("slot set on a result without a slot");

  a_removed_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_SWEPT) |-> (out_removed_count == '0))
    else $error("removed count on a non-sweep result");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_peer_count <= PCNT_W'(PEER_SLOTS)))
    else $error("peer count above table size");

endmodule

bind peer_table_with_aging_unit pta_chk u_pta_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_slot          (out_slot),
  .out_status        (out_status),
  .out_peer_count    (out_peer_count),
  .out_removed_count (out_removed_count)
);

`default_nettype wire
